>>> hdl/lags_pkg.sv
package lags_pkg;

	localparam int MAX_ROWS = 64;
	localparam int MAX_COLS = 64;
	localparam int ROW_W = $clog2(MAX_ROWS);
	localparam int COL_W = $clog2(MAX_COLS);
	localparam int NROW_W = $clog2(MAX_ROWS + 1);
	localparam int NCOL_W = $clog2(MAX_COLS + 1);
	localparam int CFG_W = 7;
	localparam int CFG_IDX_W = 2;
	localparam int GEN_W = 32;

	localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

	localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd1;

	localparam logic [1:0] MODE_READ = 2'd0;
	localparam logic [1:0] MODE_TOGGLE = 2'd1;
	localparam logic [1:0] MODE_STEP = 2'd2;

	localparam logic [3:0] BIRTH = 4'd3;
	localparam logic [3:0] SURVIVE = 4'd2;

	typedef struct packed {
		logic [1:0] mode;
		logic [5:0] row;
		logic [5:0] col;
	} lags_in_t;

	typedef struct packed {
		logic cell_alive;
		logic [GEN_W-1:0] generation;
		logic addr_error;
	} lags_out_t;

	typedef struct packed {
		logic [NROW_W-1:0] nrows;
		logic [NCOL_W-1:0] ncols;
		logic [MAX_COLS-1:0] col_mask;
	} lags_lim_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ACCESS,
		ST_SWEEP,
		ST_DONE
	} lags_state_t;

	function automatic logic [MAX_COLS-1:0] lags_next_row(
		input logic [MAX_COLS-1:0] above,
		input logic [MAX_COLS-1:0] mid,
		input logic [MAX_COLS-1:0] below,
		input logic [MAX_COLS-1:0] mask
	);
		logic [MAX_COLS-1:0] a;
		logic [MAX_COLS-1:0] m;
		logic [MAX_COLS-1:0] b;
		logic [MAX_COLS-1:0] res;
		logic [3:0] n;
		a = above & mask;
		m = mid & mask;
		b = below & mask;
		res = mid;
		for (int c = 0; c < MAX_COLS; c++) begin
			n = 4'(a[c]) + 4'(b[c]);
			if (c > 0) begin
				n = n + 4'(a[c-1]) + 4'(m[c-1]) + 4'(b[c-1]);
			end
			if (c < MAX_COLS - 1) begin
				n = n + 4'(a[c+1]) + 4'(m[c+1]) + 4'(b[c+1]);
			end
			if (mask[c]) begin
				res[c] = (n == BIRTH) || ((n == SURVIVE) && m[c]);
			end
		end
		return res;
	endfunction

endpackage

>>> hdl/life_automaton_grid_step.sv
// Read and toggle: the row is read on the input transfer and checked, or toggled
// and written back, in the access state. Generation step: one row per cycle through
// a three-row window. Each result is registered from the done state once the output
// register is free, and only then is a new item taken, also while a result waits.
// Reset: counter zero, both limits 64, grid dead through per-row valid flops
// (no clearing pass, the block is ready right after reset).
module life_automaton_grid_step (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input lags_pkg::lags_in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output lags_pkg::lags_out_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [lags_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [lags_pkg::CFG_W-1:0] cfg_data
);
	import lags_pkg::*;

	lags_lim_t lim;
	lags_state_t state_q, state_d;
	lags_in_t req_q;
	logic [NROW_W-1:0] arr_q;
	logic [MAX_COLS-1:0] win_prev_q;
	logic [MAX_COLS-1:0] win_cur_q;
	logic [MAX_ROWS-1:0] vld_q;
	logic rvld_s1;
	logic res_alive_q;
	logic res_err_q;
	logic [GEN_W-1:0] gen_q;
	logic out_valid_q;
	lags_out_t out_q;

	logic rd_en;
	logic [ROW_W-1:0] rd_addr;
	logic [MAX_COLS-1:0] rdata;
	logic wr_en;
	logic [ROW_W-1:0] wr_addr;
	logic [MAX_COLS-1:0] wr_data;

	logic [MAX_COLS-1:0] row_eff;
	logic [MAX_COLS-1:0] nxt_row;
	logic [MAX_COLS-1:0] step_row;
	logic [MAX_COLS-1:0] toggled;
	logic acc_err;
	logic acc_bit;
	logic in_xfer;
	logic load_out;
	logic sweep_last;

	lags_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.lim(lim)
	);

	lags_ram #(
		.WIDTH(MAX_COLS),
		.DEPTH(MAX_ROWS)
	) u_grid (
		.clk(clk),
		.we(wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re(rd_en),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	assign cfg_ready = 1'b1;
	assign in_xfer = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	assign row_eff = rvld_s1 ? rdata : '0;
	assign nxt_row = (arr_q < lim.nrows) ? row_eff : '0;
	assign step_row = lags_next_row(win_prev_q, win_cur_q, nxt_row, lim.col_mask);
	assign acc_err = (32'(req_q.row) >= 32'(lim.nrows)) || (32'(req_q.col) >= 32'(lim.ncols));
	assign acc_bit = row_eff[COL_W'(req_q.col)];
	assign toggled = row_eff ^ (MAX_COLS'(1) << COL_W'(req_q.col));
	assign sweep_last = (arr_q == lim.nrows);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		rd_en = 1'b0;
		rd_addr = '0;
		wr_en = 1'b0;
		wr_addr = ROW_W'(req_q.row);
		wr_data = toggled;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					rd_en = 1'b1;
					case (in_data.mode) inside
						MODE_READ, MODE_TOGGLE: begin
							rd_addr = ROW_W'(in_data.row);
							state_d = ST_ACCESS;
						end
						MODE_STEP: state_d = ST_SWEEP;
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_ACCESS: begin
				wr_en = (req_q.mode == MODE_TOGGLE) && !acc_err;
				state_d = ST_DONE;
			end
			ST_SWEEP: begin
				rd_en = 1'b1;
				rd_addr = ROW_W'(arr_q + NROW_W'(1));
				if (arr_q != '0) begin
					wr_en = 1'b1;
					wr_addr = ROW_W'(arr_q - NROW_W'(1));
					wr_data = step_row;
				end
				if (sweep_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rvld_s1 <= 1'b0;
			arr_q <= '0;
			gen_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (rd_en) begin
				rvld_s1 <= vld_q[rd_addr];
			end
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (in_xfer) begin
				arr_q <= '0;
			end else if (state_q == ST_SWEEP) begin
				arr_q <= arr_q + NROW_W'(1);
			end
			if (state_q == ST_SWEEP && sweep_last) begin
				gen_q <= gen_q + GEN_W'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			req_q <= in_data;
			win_prev_q <= '0;
			win_cur_q <= '0;
			res_alive_q <= 1'b0;
			res_err_q <= 1'b0;
		end
		if (state_q == ST_SWEEP) begin
			win_prev_q <= win_cur_q;
			win_cur_q <= nxt_row;
		end
		if (state_q == ST_ACCESS) begin
			res_err_q <= acc_err;
			res_alive_q <= !acc_err && (acc_bit ^ (req_q.mode == MODE_TOGGLE));
		end
		if (load_out) begin
			out_q.cell_alive <= res_alive_q;
			out_q.generation <= gen_q;
			out_q.addr_error <= res_err_q;
		end
	end

	a_wr_in_area: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> 32'(wr_addr) < 32'(lim.nrows))
		else $error("grid write outside active rows");

	a_sweep_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP && wr_en) |-> rd_addr != wr_addr)
		else $error("sweep reads the row being written");

	a_sweep_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SWEEP |-> 32'(arr_q) <= 32'(lim.nrows))
		else $error("sweep ran past the last row");

	a_gen_on_step: assert property (@(posedge clk) disable iff (!arst_n)
		(gen_q != $past(gen_q)) |-> $past(state_q == ST_SWEEP))
		else $error("generation count moved outside a step");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised without a finished item");

endmodule

>>> hdl/lags_ram.sv
module lags_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/lags_cfg.sv
module lags_cfg (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	input logic [lags_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [lags_pkg::CFG_W-1:0] cfg_data,
	output lags_pkg::lags_lim_t lim
);
	import lags_pkg::*;

	logic [CFG_W-1:0] cols_q;
	logic [CFG_W-1:0] rows_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= CFG_RESET;
			rows_q <= CFG_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_COLS: cols_q <= cfg_data;
				REG_ROWS: rows_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp to 1..MAX
	always_comb begin
		if (cols_q == '0) begin
			lim.ncols = NCOL_W'(1);
		end else if (32'(cols_q) > 32'(MAX_COLS)) begin
			lim.ncols = NCOL_W'(MAX_COLS);
		end else begin
			lim.ncols = NCOL_W'(cols_q);
		end
		if (rows_q == '0) begin
			lim.nrows = NROW_W'(1);
		end else if (32'(rows_q) > 32'(MAX_ROWS)) begin
			lim.nrows = NROW_W'(MAX_ROWS);
		end else begin
			lim.nrows = NROW_W'(rows_q);
		end
		for (int c = 0; c < MAX_COLS; c++) begin
			lim.col_mask[c] = 32'(c) < 32'(lim.ncols);
		end
	end

endmodule
